// ----- rtl/shes_pkg.sv -----
`default_nettype none

package shes_pkg;

  localparam int POS_WIDTH_DEF   = 24;
  localparam int SAMPLE_BITS_DEF = 12;

  localparam int LIMIT_W    = 12;
  localparam int DELAY_W    = 16;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_ADDR_W = 3;

  localparam logic [LIMIT_W-1:0] LIGHT_LIMIT_RST     = 12'd200;
  localparam logic [LIMIT_W-1:0] DARK_LIMIT_RST      = 12'd600;
  localparam logic [LIMIT_W-1:0] START_THRESHOLD_RST = 12'd400;
  localparam logic [DELAY_W-1:0] CRUISE_DELAY_RST    = 16'd1500;
  localparam logic [DELAY_W-1:0] APPROACH_DELAY_RST  = 16'd2500;
  localparam logic [DELAY_W-1:0] FINE_SPAN_RST       = 16'd400;
  localparam logic [DELAY_W-1:0] SPAN_GROWTH_RST     = 16'd500;
  localparam logic [DELAY_W-1:0] SWEEP_SPAN_RST      = 16'd1000;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_LIGHT_LIMIT     = 3'd0,
    CFG_DARK_LIMIT      = 3'd1,
    CFG_START_THRESHOLD = 3'd2,
    CFG_CRUISE_DELAY    = 3'd3,
    CFG_APPROACH_DELAY  = 3'd4,
    CFG_FINE_SPAN       = 3'd5,
    CFG_SPAN_GROWTH     = 3'd6
  } cfg_reg_t;

endpackage

`default_nettype wire

// ----- rtl/shes_if.sv -----
`default_nettype none

interface shes_cmd_if #(
  parameter int SAMPLE_BITS = shes_pkg::SAMPLE_BITS_DEF
);
  logic                   valid;
  logic                   ready;
  logic                   op;
  logic [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output op, output sample, input ready);
  modport sink (input valid, input op, input sample, output ready);
endinterface

interface shes_res_if;
  logic                            valid;
  logic                            ready;
  logic                            step_pulse;
  logic                            dir_right;
  logic [shes_pkg::DELAY_W-1:0]    step_delay_us;
  logic                            motor_enable;
  logic                            homing_active;
  logic                            homing_done;
  logic                            fine_phase;

  modport source (
    output valid, output step_pulse, output dir_right, output step_delay_us,
    output motor_enable, output homing_active, output homing_done, output fine_phase,
    input ready
  );
  modport sink (
    input valid, input step_pulse, input dir_right, input step_delay_us,
    input motor_enable, input homing_active, input homing_done, input fine_phase,
    output ready
  );
endinterface

`default_nettype wire

// ----- rtl/stepper_homing_edge_search.sv -----
// Homing sequencer for a stepper axis with a reflective light sensor.
// Items arrive on the cmd channel: op low starts homing unless it runs or is done,
// any item during a run is one step tick, and each item carries its sensor sample.
// Every item produces exactly one item on the res channel with the step
// pulse, the direction pin, the wait before the next tick and the status flags.
// The update is a single register stage: the result of an accepted item shows
// on res in the cycle after it is accepted.
// Throughput is one item per cycle while the receiver takes results; the state
// registers and the result register are both loaded at the accepting edge.
// When the receiver stalls, the result register holds its item and cmd.ready
// drops until that item is taken; an item is accepted in the same cycle as
// the held result leaves.
// The limits, delays and sweep settings are written through the cfg port, and
// the user writes them only while the block is idle; the block does not enforce it.
// Synchronous reset restores the register defaults, stops the motor, clears
// the homing flags and empties the result register.
`default_nettype none

module stepper_homing_edge_search #(
  parameter int POS_WIDTH   = shes_pkg::POS_WIDTH_DEF,
  parameter int SAMPLE_BITS = shes_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_wr_en,
  input  wire logic [shes_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [shes_pkg::CFG_DATA_W-1:0] cfg_data,
  shes_cmd_if.sink                             cmd,
  shes_res_if.source                           res
);
  import shes_pkg::*;

  localparam int CMP_W = (SAMPLE_BITS > LIMIT_W) ? SAMPLE_BITS : LIMIT_W;
  localparam int PW    = POS_WIDTH;

  localparam logic signed [PW-1:0] POS_MAX = {1'b0, {(PW-1){1'b1}}};
  localparam logic signed [PW-1:0] POS_MIN = {1'b1, {(PW-1){1'b0}}};
  localparam logic [PW:0]          SPAN_MAX_EXT = {2'b00, {(PW-1){1'b1}}};

  typedef enum logic [1:0] {
    MOT_STOP  = 2'd0,
    MOT_RIGHT = 2'd1,
    MOT_LEFT  = 2'd2
  } motion_t;

  logic [LIMIT_W-1:0] light_limit, dark_limit, start_threshold;
  logic [DELAY_W-1:0] cruise_delay_us, approach_delay_us, fine_span, span_growth;

  logic                 active, done, enabled, coarse_phase, seek_dark, dir_pin;
  motion_t              motion;
  logic signed [PW-1:0] rel_position;
  logic [PW-1:0]        sweep_span;

  logic                 active_next, done_next, enabled_next, coarse_next, seek_next;
  logic                 dir_next;
  motion_t              motion_next;
  logic signed [PW-1:0] pos_next;
  logic [PW-1:0]        span_next;
  logic                 step;
  logic [DELAY_W-1:0]   delay;

  logic                 start, below, hit, tick_en, coarse0, seek0, dir0, dir1, coarse1;
  motion_t              m0, m1;
  logic signed [PW-1:0] p0, p1;
  logic [PW-1:0]        sp1;
  logic signed [PW:0]   pos_ext, span_ext;
  logic [PW:0]          span_sum;
  logic [CMP_W-1:0]     samp, light_ext, dark_ext, thr_ext;

  logic res_valid;
  logic accept;

  assign cmd.ready = !res_valid || res.ready;
  assign accept    = cmd.valid && cmd.ready;
  assign res.valid = res_valid;

  assign samp      = CMP_W'(cmd.sample);
  assign light_ext = CMP_W'(light_limit);
  assign dark_ext  = CMP_W'(dark_limit);
  assign thr_ext   = CMP_W'(start_threshold);

  always_comb begin
    start = !done && !cmd.op && !active;
    below = samp < thr_ext;
    if (start) begin
      seek0   = below;
      m0      = below ? MOT_LEFT : MOT_RIGHT;
      dir0    = !below;
      coarse0 = 1'b1;
      p0      = '0;
    end else begin
      seek0   = seek_dark;
      m0      = motion;
      dir0    = dir_pin;
      coarse0 = coarse_phase;
      p0      = rel_position;
    end
    enabled_next = enabled || start;
    tick_en      = (active || start) && (m0 != MOT_STOP);
    hit          = seek0 ? (samp >= dark_ext) : (samp <= light_ext);

    coarse1     = coarse0;
    p1          = p0;
    sp1         = sweep_span;
    seek_next   = seek0;
    m1          = m0;
    dir1        = dir0;
    done_next   = done;
    active_next = active || start;
    if (tick_en && hit) begin
      if (coarse0) begin
        coarse1   = 1'b0;
        p1        = '0;
        sp1       = PW'(fine_span);
        seek_next = !seek0;
        m1        = (m0 == MOT_RIGHT) ? MOT_LEFT : MOT_RIGHT;
        dir1      = (m0 != MOT_RIGHT);
      end else begin
        m1          = MOT_STOP;
        done_next   = 1'b1;
        active_next = 1'b0;
      end
    end
    step  = tick_en && !(hit && !coarse0);
    delay = ((samp >= light_ext) && (samp < dark_ext)) ? approach_delay_us
                                                        : cruise_delay_us;

    // Fine sweep turns at +span and at -span; the span grows at each turn at -span.
    pos_ext     = {p1[PW-1], p1};
    span_ext    = $signed({1'b0, sp1});
    span_sum    = {1'b0, sp1} + (PW+1)'(span_growth);
    motion_next = m1;
    dir_next    = dir1;
    span_next   = sp1;
    if (step && !coarse1) begin
      if (m1 == MOT_RIGHT && pos_ext >= span_ext) begin
        motion_next = MOT_LEFT;
        dir_next    = 1'b0;
      end else if (m1 == MOT_LEFT && pos_ext <= -span_ext) begin
        motion_next = MOT_RIGHT;
        dir_next    = 1'b1;
        span_next   = (span_sum > SPAN_MAX_EXT) ? SPAN_MAX_EXT[PW-1:0] : span_sum[PW-1:0];
      end
    end
    coarse_next = coarse1;

    pos_next = p1;
    if (step) begin
      if (motion_next == MOT_RIGHT && p1 != POS_MAX) begin
        pos_next = p1 + PW'(1);
      end else if (motion_next == MOT_LEFT && p1 != POS_MIN) begin
        pos_next = p1 - PW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      light_limit       <= LIGHT_LIMIT_RST;
      dark_limit        <= DARK_LIMIT_RST;
      start_threshold   <= START_THRESHOLD_RST;
      cruise_delay_us   <= CRUISE_DELAY_RST;
      approach_delay_us <= APPROACH_DELAY_RST;
      fine_span         <= FINE_SPAN_RST;
      span_growth       <= SPAN_GROWTH_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_addr))
        CFG_LIGHT_LIMIT:     light_limit       <= cfg_data[LIMIT_W-1:0];
        CFG_DARK_LIMIT:      dark_limit        <= cfg_data[LIMIT_W-1:0];
        CFG_START_THRESHOLD: start_threshold   <= cfg_data[LIMIT_W-1:0];
        CFG_CRUISE_DELAY:    cruise_delay_us   <= cfg_data[DELAY_W-1:0];
        CFG_APPROACH_DELAY:  approach_delay_us <= cfg_data[DELAY_W-1:0];
        CFG_FINE_SPAN:       fine_span         <= cfg_data[DELAY_W-1:0];
        CFG_SPAN_GROWTH:     span_growth       <= cfg_data[DELAY_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active       <= 1'b0;
      done         <= 1'b0;
      enabled      <= 1'b0;
      coarse_phase <= 1'b1;
      seek_dark    <= 1'b1;
      dir_pin      <= 1'b0;
      motion       <= MOT_STOP;
      rel_position <= '0;
      sweep_span   <= PW'(SWEEP_SPAN_RST);
      res_valid    <= 1'b0;
    end else begin
      if (accept) begin
        active       <= active_next;
        done         <= done_next;
        enabled      <= enabled_next;
        coarse_phase <= coarse_next;
        seek_dark    <= seek_next;
        dir_pin      <= dir_next;
        motion       <= motion_next;
        rel_position <= pos_next;
        sweep_span   <= span_next;
        res_valid    <= 1'b1;
      end else if (res.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res.step_pulse    <= step;
      res.dir_right     <= dir_next;
      res.step_delay_us <= step ? delay : '0;
      res.motor_enable  <= enabled_next;
      res.homing_active <= active_next;
      res.homing_done   <= done_next;
      res.fine_phase    <= active_next && !coarse_next;
    end
  end

`ifndef SYNTHESIS
  a_done_not_active: assert property (@(posedge clk) disable iff (rst)
    !(done && active))
    else $error("homing is both active and done");

  a_done_sticks: assert property (@(posedge clk) disable iff (rst)
    done |=> done)
    else $error("homing done flag cleared without reset");

  a_active_moving: assert property (@(posedge clk) disable iff (rst)
    active |-> (motion != MOT_STOP))
    else $error("motor stopped while homing is active");

  a_step_needs_active: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.step_pulse) |-> (res.homing_active && res.motor_enable))
    else $error("step issued outside an active homing run");

  a_enable_from_start: assert property (@(posedge clk) disable iff (rst)
    (active || done) |-> enabled)
    else $error("homing ran without the motor enabled");
`endif

endmodule

`default_nettype wire
